/* hdl/afse_pkg.sv */
// ----------------------------------------------------------------------------
// afse_pkg
// Shared types and constants of the AIS frame symbol encoder.
// ----------------------------------------------------------------------------
package afse_pkg;

    localparam int BYTE_W    = 8;
    localparam int SYM_W     = 3;
    localparam int CRC_W     = 16;
    localparam int COUNT_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0] MAX_DATA_BYTES = 6'd32;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [BYTE_W-1:0] TRAINING_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] FLAG_RESET     = 8'h7E;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAINING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 2'd1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic              hdr;
        logic              dat;
        logic              ovf;
        logic              cls;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] training;
        logic [BYTE_W-1:0] flag;
    } t_cfg;

endpackage

/* hdl/afse_if.sv */
// ----------------------------------------------------------------------------
// afse_if
// Channel interfaces: message bytes in, modulator symbols out, register write.
// ----------------------------------------------------------------------------
interface afse_in_if
    import afse_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source(output valid, data_byte, last_byte, input ready);
    modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface afse_out_if
    import afse_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             frame_end;
    logic             overflow;

    modport source(output valid, symbol, frame_end, overflow, input ready);
    modport sink(input valid, symbol, frame_end, overflow, output ready);
endinterface

interface afse_cfg_if
    import afse_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* hdl/ais_frame_symbol_encoder_top.sv */
// ----------------------------------------------------------------------------
// ais_frame_symbol_encoder_top
// AIS frame encoder: header, LSB-first data with CRC-16, bit stuffing, NRZI
// and 3-bit modulator symbols.
//
//   channel  dir  payload                        transfer
//   i_byte   in   data_byte[7:0], last_byte      valid && ready
//   o_sym    out  symbol[2:0], frame_end, overflow valid && ready
//   i_cfg    in   index[1:0], data[7:0]          valid && ready (always ready)
//
// One symbol per cycle from the bit sequencer while o_sym is ready and
// commands are queued. A dropped byte that does not close the frame gives
// no symbols.
// Reset is synchronous; no clearing pass.
// A two-entry command queue lets bytes transfer while symbols are stalled.
// ----------------------------------------------------------------------------
module ais_frame_symbol_encoder_top
    import afse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    afse_in_if.sink    i_byte,
    afse_out_if.source o_sym,
    afse_cfg_if.sink   i_cfg
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.training <= TRAINING_RESET;
            r_cfg.flag     <= FLAG_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_TRAINING) begin
                r_cfg.training <= i_cfg.data;
            end
            if (i_cfg.index == CFG_FLAG) begin
                r_cfg.flag <= i_cfg.data;
            end
        end
    end

    afse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (q_full)
    );

    afse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty)
    );

    afse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_sym   (o_sym)
    );

    a_end_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym.valid && o_sym.frame_end |-> o_sym.symbol[1] == o_sym.symbol[0])
        else $error("final symbol shows a transition");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("command pushed into a full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("command popped from an empty queue");

endmodule

/* hdl/afse_front.sv */
// ----------------------------------------------------------------------------
// afse_front
// Accepts message bytes, tracks frame position and byte count, and turns each
// byte into a command for the bit sequencer.
// ----------------------------------------------------------------------------
module afse_front
    import afse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    afse_in_if.sink    i_byte,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);

    logic               r_in_frame, n_in_frame;
    logic [COUNT_W-1:0] r_count, n_count;

    assign i_byte.ready = !i_full;
    assign o_push       = i_byte.valid && !i_full;

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        o_cmd      = '0;
        o_cmd.data = i_byte.data_byte;
        if (!r_in_frame) begin
            o_cmd.hdr  = 1'b1;
            o_cmd.dat  = 1'b1;
            n_in_frame = 1'b1;
            n_count    = COUNT_W'(1);
        end else begin
            if (r_count < MAX_DATA_BYTES) begin
                o_cmd.dat = 1'b1;
                n_count   = r_count + COUNT_W'(1);
            end else begin
                o_cmd.ovf = 1'b1;
            end
            if (i_byte.last_byte) begin
                o_cmd.cls  = 1'b1;
                n_in_frame = 1'b0;
                n_count    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else if (o_push) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

endmodule

/* hdl/afse_queue.sv */
// ----------------------------------------------------------------------------
// afse_queue
// Two-entry command queue between the byte front end and the bit sequencer.
// ----------------------------------------------------------------------------
module afse_queue
    import afse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_used;
    logic              wr;
    logic              rd;

    assign o_full  = (r_used == QCNT_W'(QDEPTH));
    assign o_empty = (r_used == '0);
    assign o_cmd   = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_used <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (rd) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({wr, rd})
                2'b10:   r_used <= r_used + QCNT_W'(1);
                2'b01:   r_used <= r_used - QCNT_W'(1);
                default: r_used <= r_used;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

/* hdl/afse_back.sv */
// ----------------------------------------------------------------------------
// afse_back
// Bit sequencer: header, data with CRC and bit stuffing, closing CRC and flag,
// NRZI coding and symbol forming, one line bit per cycle into an output
// register while the output is not stalled and commands are queued.
// ----------------------------------------------------------------------------
module afse_back
    import afse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    afse_out_if.source o_sym
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_RAMP  = 3'd1;
    localparam logic [2:0] PH_TRAIN = 3'd2;
    localparam logic [2:0] PH_FLAG  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRC   = 3'd5;
    localparam logic [2:0] PH_EFLAG = 3'd6;
    localparam logic [2:0] PH_FINAL = 3'd7;

    localparam logic [4:0] RAMP_LAST  = 5'd6;
    localparam logic [4:0] TRAIN_LAST = 5'd23;
    localparam logic [4:0] BYTE_LAST  = 5'd7;
    localparam logic [4:0] BYTE_BITS  = 5'd8;
    localparam logic [4:0] CRC_LAST   = 5'd15;
    localparam logic [4:0] CRC_BITS   = 5'd16;
    localparam logic [2:0] STUFF_RUN  = 3'd5;

    logic [2:0]       r_phase, n_phase;
    logic [4:0]       r_cnt, n_cnt;
    t_cmd             r_cmd, n_cmd;
    logic [CRC_W-1:0] r_crc, n_crc;
    logic [2:0]       r_ones, n_ones;
    logic             r_stuff, n_stuff;
    logic             r_line, n_line;
    logic             r_prev, n_prev;
    logic             r_held, n_held;
    logic             r_ovf, n_ovf;
    logic             r_o_valid, n_o_valid;
    logic [SYM_W-1:0] r_o_sym, n_o_sym;
    logic             r_o_end, n_o_end;
    logic             r_o_ovf, n_o_ovf;

    logic             adv;
    logic             push;
    logic             nrzi;
    logic             b;
    logic             lv;
    logic             done;
    logic [CRC_W-1:0] fcs;
    logic [2:0]       ones_inc;

    assign o_sym.valid     = r_o_valid;
    assign o_sym.symbol    = r_o_sym;
    assign o_sym.frame_end = r_o_end;
    assign o_sym.overflow  = r_o_ovf;

    assign fcs      = ~r_crc;
    assign ones_inc = r_ones + 3'd1;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_cmd     = r_cmd;
        n_crc     = r_crc;
        n_ones    = r_ones;
        n_stuff   = r_stuff;
        n_line    = r_line;
        n_prev    = r_prev;
        n_held    = r_held;
        n_ovf     = r_ovf;
        n_o_valid = r_o_valid;
        n_o_sym   = r_o_sym;
        n_o_end   = r_o_end;
        n_o_ovf   = r_o_ovf;
        o_pop     = 1'b0;
        push      = 1'b0;
        nrzi      = 1'b1;
        b         = 1'b0;
        done      = 1'b0;

        if (r_o_valid && o_sym.ready) begin
            n_o_valid = 1'b0;
        end

        adv = (r_phase != PH_IDLE) && (!r_o_valid || o_sym.ready);

        if (adv) begin
            case (r_phase)
                PH_RAMP: begin
                    push  = 1'b1;
                    nrzi  = 1'b0;
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == RAMP_LAST) begin
                        n_phase = PH_TRAIN;
                        n_cnt   = '0;
                    end
                end
                PH_TRAIN: begin
                    push  = 1'b1;
                    b     = i_cfg.training[~r_cnt[2:0]];
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == TRAIN_LAST) begin
                        n_phase = PH_FLAG;
                        n_cnt   = '0;
                    end
                end
                PH_FLAG: begin
                    push  = 1'b1;
                    b     = i_cfg.flag[~r_cnt[2:0]];
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == BYTE_LAST) begin
                        n_phase = PH_DATA;
                        n_cnt   = '0;
                    end
                end
                PH_DATA, PH_CRC: begin
                    push = 1'b1;
                    if (r_stuff) begin
                        b       = 1'b0;
                        n_stuff = 1'b0;
                        if ((r_phase == PH_DATA && r_cnt == BYTE_BITS) ||
                            (r_phase == PH_CRC && r_cnt == CRC_BITS)) begin
                            done = 1'b1;
                        end
                    end else begin
                        if (r_phase == PH_DATA) begin
                            b     = r_cmd.data[r_cnt[2:0]];
                            n_crc = {r_crc[CRC_W-2:0], 1'b0} ^
                                    ((r_crc[CRC_W-1] ^ b) ? CRC_POLY : '0);
                        end else begin
                            b = fcs[~r_cnt[3:0]];
                        end
                        n_cnt = r_cnt + 5'd1;
                        if (b) begin
                            if (ones_inc == STUFF_RUN) begin
                                n_stuff = 1'b1;
                                n_ones  = '0;
                            end else begin
                                n_ones = ones_inc;
                            end
                        end else begin
                            n_ones = '0;
                        end
                        if (!n_stuff &&
                            ((r_phase == PH_DATA && r_cnt == BYTE_LAST) ||
                             (r_phase == PH_CRC && r_cnt == CRC_LAST))) begin
                            done = 1'b1;
                        end
                    end
                    if (done) begin
                        if (r_phase == PH_DATA && r_cmd.cls) begin
                            done    = 1'b0;
                            n_phase = PH_CRC;
                            n_cnt   = '0;
                        end else if (r_phase == PH_CRC) begin
                            done    = 1'b0;
                            n_phase = PH_EFLAG;
                            n_cnt   = '0;
                        end
                    end
                end
                PH_EFLAG: begin
                    push  = 1'b1;
                    b     = i_cfg.flag[~r_cnt[2:0]];
                    n_cnt = r_cnt + 5'd1;
                    if (r_cnt == BYTE_LAST) begin
                        n_phase = PH_FINAL;
                        n_cnt   = '0;
                    end
                end
                PH_FINAL: begin
                    n_o_valid = 1'b1;
                    n_o_sym   = {r_prev, r_held, r_held};
                    n_o_end   = 1'b1;
                    n_o_ovf   = r_ovf;
                    n_ones    = '0;
                    n_crc     = CRC_INIT;
                    done      = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end

        lv = nrzi ? (b ? r_line : ~r_line) : 1'b0;

        if (push) begin
            n_line    = lv;
            n_prev    = r_held;
            n_held    = lv;
            n_o_valid = 1'b1;
            n_o_sym   = {r_prev, r_held, lv};
            n_o_end   = 1'b0;
            n_o_ovf   = r_ovf;
        end

        if (r_phase == PH_IDLE || done) begin
            n_phase = PH_IDLE;
            if (!i_empty) begin
                o_pop = 1'b1;
                n_cmd = i_cmd;
                n_cnt = '0;
                if (i_cmd.ovf) begin
                    n_ovf = 1'b1;
                end
                if (i_cmd.hdr) begin
                    n_phase = PH_RAMP;
                    n_crc   = CRC_INIT;
                    n_ones  = '0;
                    n_stuff = 1'b0;
                    n_line  = 1'b0;
                    n_prev  = 1'b0;
                    n_held  = 1'b0;
                    n_ovf   = 1'b0;
                end else if (i_cmd.dat) begin
                    n_phase = PH_DATA;
                end else if (i_cmd.cls) begin
                    n_phase = PH_CRC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_crc     <= CRC_INIT;
            r_ones    <= '0;
            r_stuff   <= 1'b0;
            r_line    <= 1'b0;
            r_prev    <= 1'b0;
            r_held    <= 1'b0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_crc     <= n_crc;
            r_ones    <= n_ones;
            r_stuff   <= n_stuff;
            r_line    <= n_line;
            r_prev    <= n_prev;
            r_held    <= n_held;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_o_sym <= n_o_sym;
        r_o_end <= n_o_end;
        r_o_ovf <= n_o_ovf;
    end

endmodule

/* bench/afse_tb_pkg.sv */
// ----------------------------------------------------------------------------
// afse_tb_pkg
// Symbol tracker for the AIS frame symbol encoder bench. It keeps its own copy
// of the encoder state and registers and turns each accepted message byte
// into the modulator symbols the block must produce. It then matches the
// symbols that come out against them, in order.
// ----------------------------------------------------------------------------
package afse_tb_pkg;
    import afse_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             frame_end;
        logic             overflow;
    } t_sym_result;

    class afse_symbol_tracker;
        logic [BYTE_W-1:0]  training;
        logic [BYTE_W-1:0]  flag;
        logic [CRC_W-1:0]   crc;
        logic [2:0]         ones;
        logic               line_lv;
        logic               prev_lv;
        logic               held_lv;
        logic               in_frame;
        logic               ovf_seen;
        logic [COUNT_W-1:0] byte_cnt;
        t_sym_result        expected_symbols[$];
        int                 errors;

        function new();
            training = TRAINING_RESET;
            flag     = FLAG_RESET;
            crc      = CRC_INIT;
            ones     = '0;
            line_lv  = 1'b0;
            prev_lv  = 1'b0;
            held_lv  = 1'b0;
            in_frame = 1'b0;
            ovf_seen = 1'b0;
            byte_cnt = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            case (idx)
                CFG_TRAINING: training = val;
                CFG_FLAG:     flag = val;
                default: ;
            endcase
        endfunction

        function void emit(logic [SYM_W-1:0] sym, logic fend);
            t_sym_result r;
            r.symbol    = sym;
            r.frame_end = fend;
            r.overflow  = ovf_seen;
            expected_symbols.push_back(r);
        endfunction

        function void push_level(logic lv);
            emit({prev_lv, held_lv, lv}, 1'b0);
            prev_lv = held_lv;
            held_lv = lv;
        endfunction

        function void line_bit(logic b);
            if (!b) begin
                line_lv = ~line_lv;
            end
            push_level(line_lv);
        endfunction

        function void send_msb(logic [BYTE_W-1:0] v);
            for (int k = BYTE_W - 1; k >= 0; k--) begin
                line_bit(v[k]);
            end
        endfunction

        function void stuffed_bit(logic b);
            line_bit(b);
            if (b) begin
                ones = ones + 3'd1;
                if (ones >= 3'd5) begin
                    line_bit(1'b0);
                    ones = '0;
                end
            end else begin
                ones = '0;
            end
        endfunction

        function void send_data(logic [BYTE_W-1:0] v);
            logic fb;
            for (int k = 0; k < BYTE_W; k++) begin
                fb  = crc[CRC_W-1] ^ v[k];
                crc = crc << 1;
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
                stuffed_bit(v[k]);
            end
        endfunction

        function void open_frame();
            crc      = CRC_INIT;
            ones     = '0;
            line_lv  = 1'b0;
            prev_lv  = 1'b0;
            held_lv  = 1'b0;
            ovf_seen = 1'b0;
            byte_cnt = '0;
            in_frame = 1'b1;
            repeat (7) push_level(1'b0);
            repeat (3) send_msb(training);
            send_msb(flag);
        endfunction

        function void close_frame();
            logic [CRC_W-1:0] fcs;
            fcs = ~crc;
            for (int k = CRC_W - 1; k >= 0; k--) begin
                stuffed_bit(fcs[k]);
            end
            send_msb(flag);
            emit({prev_lv, held_lv, held_lv}, 1'b1);
            in_frame = 1'b0;
            ones     = '0;
            byte_cnt = '0;
            crc      = CRC_INIT;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] v, logic last);
            if (!in_frame) begin
                open_frame();
                send_data(v);
                byte_cnt = 6'd1;
            end else begin
                if (byte_cnt < MAX_DATA_BYTES) begin
                    send_data(v);
                    byte_cnt = byte_cnt + 6'd1;
                end else begin
                    ovf_seen = 1'b1;
                end
                if (last) begin
                    close_frame();
                end
            end
        endfunction

        function void match_symbol(logic [SYM_W-1:0] sym, logic fend, logic ovf);
            t_sym_result want;
            if (expected_symbols.size() == 0) begin
                $display("%0t: unexpected symbol %0d frame_end %0b overflow %0b",
                         $time, sym, fend, ovf);
                errors++;
                return;
            end
            want = expected_symbols.pop_front();
            if (want.symbol !== sym) begin
                $display("%0t: symbol mismatch: expected %0d, actual %0d",
                         $time, want.symbol, sym);
                errors++;
            end
            if (want.frame_end !== fend) begin
                $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                         $time, want.frame_end, fend);
                errors++;
            end
            if (want.overflow !== ovf) begin
                $display("%0t: overflow mismatch: expected %0b, actual %0b",
                         $time, want.overflow, ovf);
                errors++;
            end
        endfunction
    endclass

endpackage

/* bench/ais_frame_symbol_encoder_top_tb.sv */
// ----------------------------------------------------------------------------
// ais_frame_symbol_encoder_top_tb
// Drives message frames into the AIS frame symbol encoder under changing
// training and flag settings, with random gaps and output stalls, one long
// output hold-off and overflowing frames. Every symbol is checked in order
// against the symbol tracker.
// ----------------------------------------------------------------------------
module ais_frame_symbol_encoder_top_tb
    import afse_pkg::*, afse_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 170;
    localparam int QUIET_FROM   = 140;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 16;
    localparam int TAIL_CYCLES  = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_req = 1'b0;
    logic stall_en = 1'b1;
    logic gap_en   = 1'b1;

    afse_symbol_tracker trk;

    afse_in_if  byte_if();
    afse_out_if sym_if();
    afse_cfg_if cfg_if();

    ais_frame_symbol_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_sym   (sym_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                trk.set_reg(cfg_if.index, cfg_if.data);
            end
            if (byte_if.valid && byte_if.ready) begin
                trk.take_byte(byte_if.data_byte, byte_if.last_byte);
            end
            if (sym_if.valid && sym_if.ready) begin
                trk.match_symbol(sym_if.symbol, sym_if.frame_end, sym_if.overflow);
            end
        end
    end

    initial begin
        sym_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                sym_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                sym_if.ready <= 1'b1;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                sym_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                sym_if.ready <= 1'b1;
            end else begin
                sym_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= last;
        do @(posedge i_clk); while (!byte_if.ready);
    endtask

    task automatic byte_gap();
        if (gap_en && $urandom_range(0, 3) == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (trk.expected_symbols.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_reg();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int                item_cnt;
        int                frame_idx;
        int                len;
        logic              lst;
        logic [BYTE_W-1:0] b;

        trk = new();
        i_rst_n           <= 1'b0;
        byte_if.valid     <= 1'b0;
        byte_if.data_byte <= '0;
        byte_if.last_byte <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        wait_drained();

        write_reg(CFG_TRAINING, 8'h00);
        write_reg(CFG_FLAG, 8'hFF);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'h1F, 1'b1);
        wait_drained();

        write_reg(CFG_TRAINING, 8'hFF);
        write_reg(CFG_FLAG, 8'h00);
        write_reg(CFG_SPARE_A, 8'hFF);
        write_reg(CFG_SPARE_B, 8'h00);
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();

        write_reg(CFG_TRAINING, TRAINING_RESET);
        write_reg(CFG_FLAG, FLAG_RESET);

        item_cnt  = 0;
        frame_idx = 0;
        while (item_cnt < RANDOM_ITEMS) begin
            if (frame_idx % 6 == 0 && item_cnt < QUIET_FROM) begin
                wait_drained();
                write_reg(CFG_TRAINING, rand_reg());
                write_reg(CFG_FLAG, rand_reg());
                if ($urandom_range(0, 1) == 0) begin
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, rand_reg());
                end
            end
            if (item_cnt >= QUIET_FROM) begin
                stall_en = 1'b0;
                gap_en   = 1'b0;
            end
            if (frame_idx == 3) begin
                hold_req = 1'b1;
            end
            if (frame_idx == 2) begin
                len = 35;
            end else if (frame_idx == 5) begin
                len = 33;
            end else if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(30, 36);
            end else begin
                len = $urandom_range(2, 6);
            end
            for (int k = 0; k < len; k++) begin
                b   = ($urandom_range(0, 3) == 0) ? 8'hFF : BYTE_W'($urandom_range(0, 255));
                lst = (k == 0) ? 1'($urandom_range(0, 1)) : (k == len - 1);
                send_byte(b, lst);
                item_cnt++;
                if (k == 0 && item_cnt < QUIET_FROM && $urandom_range(0, 7) == 0) begin
                    wait_drained();
                    write_reg(CFG_FLAG, rand_reg());
                end else begin
                    byte_gap();
                end
            end
            frame_idx++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (trk.expected_symbols.size() != 0) begin
            $display("%0t: %0d expected symbols never arrived",
                     $time, trk.expected_symbols.size());
        end
        if (trk.errors == 0 && trk.expected_symbols.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/afse_pkg.sv
hdl/afse_if.sv
hdl/afse_front.sv
hdl/afse_queue.sv
hdl/afse_back.sv
hdl/ais_frame_symbol_encoder_top.sv
bench/afse_tb_pkg.sv
bench/ais_frame_symbol_encoder_top_tb.sv
